FILE: design/combination_enumerator_core_macros.svh
// Assertion macros shared by the checker of the combination enumerator.
`ifndef COMBINATION_ENUMERATOR_CORE_MACROS_SVH
`define COMBINATION_ENUMERATOR_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while reset is asserted.
`define CEC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while reset is asserted.
`define CEC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/cenum_pkg.sv
// Types and constants of the combination enumerator.
package cenum_pkg;
	localparam int RADIX      = 10;
	localparam int MAX_DIGITS = 10;
	localparam int DIGIT_W    = 4;
	localparam int SIZE_W     = 4;
	localparam int DIGITS_W   = MAX_DIGITS * DIGIT_W;
	localparam int SIZE_CAP   = (RADIX < MAX_DIGITS) ? RADIX : MAX_DIGITS;

	typedef logic [DIGIT_W-1:0] digit_t;
	typedef logic [SIZE_W-1:0]  size_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic latch;  // capture the request beat
		logic step;   // emit the current combination and advance
	} cenum_cmd_t;
endpackage

FILE: design/cenum_ctrl.sv
// Controller of the combination enumerator: request/response sequencing.
module cenum_ctrl import cenum_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_stall,
	output logic       rsp_valid,
	input  logic       rsp_stall,
	output cenum_cmd_t cmd
);
	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_CALC = 1'b1;

	logic state_q, state_d;
	logic rsp_valid_q, rsp_valid_d;
	logic out_free;

	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign req_stall = (state_q != ST_IDLE);
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		state_d     = state_q;
		rsp_valid_d = rsp_valid_q && rsp_stall;
		cmd         = '0;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					cmd.latch = 1'b1;
					state_d   = ST_CALC;
				end
			end
			ST_CALC: begin
				// hold until the output register can take the new beat
				if (out_free) begin
					cmd.step    = 1'b1;
					rsp_valid_d = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			rsp_valid_q <= rsp_valid_d;
		end
	end
endmodule

FILE: design/cenum_dp.sv
// Datapath of the combination enumerator: digit state, successor logic, output register.
module cenum_dp import cenum_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  cenum_cmd_t          cmd,
	input  logic                restart,
	input  logic                cfg_wr_en,
	input  size_t               cfg_wr_data,
	output logic [DIGITS_W-1:0] digits,
	output size_t               digit_count,
	output logic                is_last,
	output logic                valid_res
);
	digit_t              cur_q [MAX_DIGITS];
	logic                exhausted_q;
	size_t               size_q;
	logic                restart_q;
	logic [DIGITS_W-1:0] digits_q;
	size_t               count_q;
	logic                last_q;
	logic                vres_q;

	size_t               k;
	digit_t              cur_eff [MAX_DIGITS];
	logic                exh_eff;
	logic [MAX_DIGITS-1:0] grow;
	logic                found;
	size_t               pos;
	digit_t              pos_digit;
	digit_t              nxt [MAX_DIGITS];
	logic [DIGITS_W-1:0] packed_d;
	logic [5:0]          limit [MAX_DIGITS];

	// saturate the size register to 1 .. SIZE_CAP
	always_comb begin
		if (size_q == '0)
			k = size_t'(1);
		else if (size_q > size_t'(SIZE_CAP))
			k = size_t'(SIZE_CAP);
		else
			k = size_q;
	end

	always_comb begin
		exh_eff = restart_q ? 1'b0 : exhausted_q;
		for (int i = 0; i < MAX_DIGITS; i++) begin
			cur_eff[i] = restart_q ? digit_t'(i) : cur_q[i];
			limit[i]   = 6'(RADIX) + 6'(i) - {2'b00, k};
			grow[i]    = (size_t'(i) < k) && ({2'b00, cur_eff[i]} < limit[i]);
			packed_d[i*DIGIT_W +: DIGIT_W] = (size_t'(i) < k) ? cur_eff[i] : '0;
		end
	end

	// rightmost position that can still grow
	always_comb begin
		found = 1'b0;
		pos   = '0;
		for (int i = 0; i < MAX_DIGITS; i++) begin
			if (grow[i]) begin
				found = 1'b1;
				pos   = size_t'(i);
			end
		end
	end

	always_comb begin
		pos_digit = cur_eff[0];
		for (int i = 0; i < MAX_DIGITS; i++) begin
			if (pos == size_t'(i))
				pos_digit = cur_eff[i];
		end
	end

	// increment the carry position, refill the tail consecutively
	always_comb begin
		for (int j = 0; j < MAX_DIGITS; j++) begin
			if (found && (size_t'(j) >= pos) && (size_t'(j) < k))
				nxt[j] = digit_t'({1'b0, pos_digit} + 5'd1 + 5'(j) - {1'b0, pos});
			else
				nxt[j] = cur_eff[j];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_DIGITS; i++)
				cur_q[i] <= digit_t'(i);
			exhausted_q <= 1'b0;
			size_q      <= size_t'(1);
			restart_q   <= 1'b0;
		end else begin
			if (cfg_wr_en)
				size_q <= cfg_wr_data;
			if (cmd.latch)
				restart_q <= restart;
			if (cmd.step && !exh_eff) begin
				for (int i = 0; i < MAX_DIGITS; i++)
					cur_q[i] <= nxt[i];
				exhausted_q <= !found;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.step) begin
			count_q  <= k;
			digits_q <= exh_eff ? '0 : packed_d;
			last_q   <= !exh_eff && !found;
			vres_q   <= !exh_eff;
		end
	end

	assign digits      = digits_q;
	assign digit_count = count_q;
	assign is_last     = last_q;
	assign valid_res   = vres_q;
endmodule

FILE: design/combination_enumerator_core.sv
// Top level of the lexicographic k-combination enumerator.
//
// Request channel (req_valid / req_stall, payload restart): each beat asks for
// one combination. restart=1 reloads the first combination 0..k-1 first.
// Response channel (rsp_valid / rsp_stall): one beat per request carrying the
// packed digits (digit 0 in bits 3:0), digit_count, is_last and valid_res.
// Once the final combination has gone out, responses carry valid_res=0 until
// a request with restart=1.
// Configuration: cfg_wr_en writes cfg_wr_data into the size register k
// (saturated to 1..10); write only while no request is in flight.
// Timing: a request is taken in the idle state; its response is loaded when
// the compute state ends, so the controller's two-state sequence takes a new
// request only after that. req_stall is high in the compute cycle.
// If the receiver stalls, the response register holds and the next result
// waits in the compute cycle until the register frees up.
// Reset: asynchronous, active low; digits return to 0..9, k to 1, no
// response pending.
module combination_enumerator_core import cenum_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  logic                restart,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output logic [DIGITS_W-1:0] digits,
	output size_t               digit_count,
	output logic                is_last,
	output logic                valid_res,
	input  logic                cfg_wr_en,
	input  size_t               cfg_wr_data
);
	cenum_cmd_t cmd;

	cenum_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.cmd       (cmd)
	);

	cenum_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.restart     (restart),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.digits      (digits),
		.digit_count (digit_count),
		.is_last     (is_last),
		.valid_res   (valid_res)
	);
endmodule

FILE: design/combination_enumerator_core_chk.sv
// Port-level checker for the combination enumerator, bound to the top level.
`include "combination_enumerator_core_macros.svh"

module combination_enumerator_core_chk import cenum_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                req_valid,
	input logic                req_stall,
	input logic                restart,
	input logic                rsp_valid,
	input logic                rsp_stall,
	input logic [DIGITS_W-1:0] digits,
	input size_t               digit_count,
	input logic                is_last,
	input logic                valid_res,
	input logic                cfg_wr_en,
	input size_t               cfg_wr_data
);
	`CEC_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(digits) && $stable(is_last) && $stable(valid_res), "stalled response beat changed")
	`CEC_ASSERT_NOW(a_exh_clean, rsp_valid && !valid_res, (digits == '0) && !is_last, "exhausted beat carries digits or last flag")
	`CEC_ASSERT_NOW(a_last_valid, rsp_valid && is_last, valid_res, "last flag on an invalid beat")
	`CEC_ASSERT_NOW(a_count_range, rsp_valid, (digit_count != '0) && (digit_count <= size_t'(SIZE_CAP)), "digit count out of range")
	`CEC_ASSERT_NEXT(a_one_at_a_time, req_valid && !req_stall, req_stall, "request taken while previous still computing")
endmodule

bind combination_enumerator_core combination_enumerator_core_chk u_chk (.*);

FILE: verif/combination_enumerator_core_test.sv
// Testbench for the combination enumerator: a directed table, then random runs, checked by an in-bench enumerator.
module combination_enumerator_core_test;
	timeunit 1ns;
	timeprecision 1ps;
	import cenum_pkg::*;

	localparam int ITEMS_TOTAL    = 900;
	localparam int LONG_HOLD      = 200;
	localparam int HOLD_AFTER     = 300;
	localparam int SETTLE_CYCLES  = 4;
	localparam int WATCHDOG_LIMIT = 2000;

	typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;
	typedef enum logic [1:0] {ROW_CFG, ROW_ITEM, ROW_TYPED} row_kind_t;

	typedef struct packed {
		logic [DIGITS_W-1:0] digits;
		size_t               count;
		logic                last;
		logic                valid;
	} combo_t;

	typedef struct packed {
		row_kind_t kind;
		size_t     size_val;
		logic      rst;
		combo_t    want;
	} plan_row_t;

	localparam combo_t NONE = '0;

	// Typed rows hold results readable straight off the enumeration order;
	// plain item rows are checked against the enumerator below.
	localparam plan_row_t PLAN [28] = '{
		'{ROW_TYPED, 4'd0,  1'b0, '{40'h0, 4'd1, 1'b0, 1'b1}},
		'{ROW_CFG,   4'd10, 1'b0, NONE},
		'{ROW_ITEM,  4'd0,  1'b0, NONE},  // stale pattern under k=10: nothing grows
		'{ROW_TYPED, 4'd0,  1'b0, '{40'h0, 4'd10, 1'b0, 1'b0}},
		'{ROW_TYPED, 4'd0,  1'b1, '{40'h9876543210, 4'd10, 1'b1, 1'b1}},
		'{ROW_CFG,   4'd0,  1'b0, NONE},  // zero size acts as one
		'{ROW_TYPED, 4'd0,  1'b1, '{40'h0, 4'd1, 1'b0, 1'b1}},
		'{ROW_ITEM,  4'd0,  1'b0, NONE},
		'{ROW_ITEM,  4'd0,  1'b0, NONE},
		'{ROW_ITEM,  4'd0,  1'b0, NONE},
		'{ROW_ITEM,  4'd0,  1'b0, NONE},
		'{ROW_ITEM,  4'd0,  1'b0, NONE},
		'{ROW_ITEM,  4'd0,  1'b0, NONE},
		'{ROW_ITEM,  4'd0,  1'b0, NONE},
		'{ROW_ITEM,  4'd0,  1'b0, NONE},
		'{ROW_TYPED, 4'd0,  1'b0, '{40'h9, 4'd1, 1'b1, 1'b1}},
		'{ROW_TYPED, 4'd0,  1'b0, '{40'h0, 4'd1, 1'b0, 1'b0}},
		'{ROW_CFG,   4'd15, 1'b0, NONE},  // saturates to ten
		'{ROW_TYPED, 4'd0,  1'b1, '{40'h9876543210, 4'd10, 1'b1, 1'b1}},
		'{ROW_CFG,   4'd9,  1'b0, NONE},
		'{ROW_TYPED, 4'd0,  1'b1, '{40'h0876543210, 4'd9, 1'b0, 1'b1}},
		'{ROW_ITEM,  4'd0,  1'b0, NONE},
		'{ROW_CFG,   4'd2,  1'b0, NONE},  // shrink k in the middle of a sequence
		'{ROW_ITEM,  4'd0,  1'b0, NONE},
		'{ROW_ITEM,  4'd0,  1'b0, NONE},
		'{ROW_CFG,   4'd11, 1'b0, NONE},
		'{ROW_ITEM,  4'd0,  1'b0, NONE},
		'{ROW_TYPED, 4'd0,  1'b1, '{40'h9876543210, 4'd10, 1'b1, 1'b1}}
	};

	logic                clk;
	logic                arst_n;
	logic                req_valid;
	logic                req_stall;
	logic                restart;
	logic                rsp_valid;
	logic                rsp_stall;
	logic [DIGITS_W-1:0] digits;
	size_t               digit_count;
	logic                is_last;
	logic                valid_res;
	logic                cfg_wr_en;
	size_t               cfg_wr_data;

	digit_t comb_digits [MAX_DIGITS];
	logic   comb_done;
	size_t  comb_k_reg;
	combo_t pending_combos [$];

	int items_sent;
	int results_seen;
	int fail_count;
	int burst_left;

	combination_enumerator_core u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.restart     (restart),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.digits      (digits),
		.digit_count (digit_count),
		.is_last     (is_last),
		.valid_res   (valid_res),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void load_first_combo();
		for (int i = 0; i < MAX_DIGITS; i++)
			comb_digits[i] = digit_t'(i);
	endfunction

	// Emit the stored combination and step to the next one in lexicographic order.
	function automatic combo_t advance_combination(input logic rst);
		combo_t r;
		int     k;
		int     pos;
		int     base;
		logic   grows;
		k = comb_k_reg;
		if (k < 1) k = 1;
		if (k > SIZE_CAP) k = SIZE_CAP;
		r = '0;
		r.count = size_t'(k);
		if (rst) begin
			load_first_combo();
			comb_done = 1'b0;
		end
		if (comb_done)
			return r;
		grows = 1'b0;
		pos = 0;
		for (int i = 0; i < k; i++) begin
			r.digits[DIGIT_W*i +: DIGIT_W] = comb_digits[i];
			if (int'(comb_digits[i]) < RADIX - k + i) begin
				grows = 1'b1;
				pos = i;
			end
		end
		if (grows) begin
			base = int'(comb_digits[pos]) + 1;
			for (int j = pos; j < k; j++)
				comb_digits[j] = digit_t'(base + j - pos);
		end else begin
			comb_done = 1'b1;
		end
		r.last  = !grows;
		r.valid = 1'b1;
		return r;
	endfunction

	// Offer one request beat, hold it until taken, then maybe open a gap.
	task automatic offer(input logic rst, input logic typed, input combo_t want);
		combo_t pred;
		req_valid <= 1'b1;
		restart   <= rst;
		do @(posedge clk); while (req_stall);
		pred = advance_combination(rst);
		pending_combos.push_back(typed ? want : pred);
		items_sent++;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(80, 200)
			                                         : $urandom_range(1, 30);
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end else begin
			burst_left--;
		end
	endtask

	task automatic drain_pause();
		req_valid <= 1'b0;
		while (pending_combos.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_size(input size_t v);
		drain_pause();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en  <= 1'b0;
		comb_k_reg = v;
	endtask

	initial begin : req_side
		size_t new_size;
		int    run_cap;
		int    run_len;
		req_valid   <= 1'b0;
		restart     <= 1'b0;
		cfg_wr_en   <= 1'b0;
		cfg_wr_data <= '0;
		arst_n      <= 1'b0;
		load_first_combo();
		comb_done  = 1'b0;
		comb_k_reg = 4'd1;
		items_sent = 0;
		fail_count = 0;
		burst_left = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (PLAN[i]) begin
			case (PLAN[i].kind)
				ROW_CFG:   write_size(PLAN[i].size_val);
				ROW_ITEM:  offer(PLAN[i].rst, 1'b0, NONE);
				default:   offer(PLAN[i].rst, 1'b1, PLAN[i].want);
			endcase
		end

		// Mostly full runs from a restart; some continue a stale pattern under a new k.
		while (items_sent < ITEMS_TOTAL) begin
			if ($urandom_range(0, 7) == 0)
				new_size = $urandom_range(0, 1) ? size_t'(0) : size_t'($urandom_range(11, 15));
			else
				new_size = size_t'($urandom_range(1, 10));
			write_size(new_size);
			run_cap = $urandom_range(20, 300);
			run_len = 0;
			offer(logic'($urandom_range(0, 3) != 0), 1'b0, NONE);
			while (!comb_done && run_len < run_cap) begin
				offer(logic'($urandom_range(0, 59) == 0), 1'b0, NONE);
				run_len++;
			end
			repeat ($urandom_range(0, 3)) offer(1'b0, 1'b0, NONE);
		end

		drain_pause();
		if (fail_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin : rsp_side
		combo_t      want;
		stall_mode_t mode;
		int          mode_left;
		int          hold_left;
		logic        hold_done;
		int          phase;
		logic        stall_next;
		mode         = STALL_NONE;
		mode_left    = 100;
		hold_left    = 0;
		hold_done    = 1'b0;
		phase        = 0;
		results_seen = 0;
		rsp_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_valid && !rsp_stall) begin
				results_seen++;
				if (pending_combos.size() == 0) begin
					$error("result beat with no request pending: digits %h", digits);
					fail_count++;
				end else begin
					want = pending_combos.pop_front();
					if (digits !== want.digits) begin
						$error("digits: expected %h, got %h", want.digits, digits);
						fail_count++;
					end
					if (digit_count !== want.count) begin
						$error("digit_count: expected %0d, got %0d", want.count, digit_count);
						fail_count++;
					end
					if (is_last !== want.last) begin
						$error("is_last: expected %b, got %b", want.last, is_last);
						fail_count++;
					end
					if (valid_res !== want.valid) begin
						$error("valid_res: expected %b, got %b", want.valid, valid_res);
						fail_count++;
					end
				end
			end
			// One long hold-off while the sender keeps offering, so the block backs up.
			if (hold_left > 0) begin
				hold_left--;
				stall_next = 1'b1;
			end else if (!hold_done && results_seen >= HOLD_AFTER && req_valid) begin
				hold_done  = 1'b1;
				hold_left  = LONG_HOLD - 1;
				stall_next = 1'b1;
			end else begin
				if (mode_left == 0) begin
					mode      = stall_mode_t'($urandom_range(0, 3));
					mode_left = $urandom_range(20, 200);
				end
				mode_left--;
				phase++;
				case (mode)
					STALL_NONE:  stall_next = 1'b0;
					STALL_LIGHT: stall_next = ($urandom_range(0, 3) == 0);
					STALL_HEAVY: stall_next = ($urandom_range(0, 3) != 0);
					default:     stall_next = (phase % 4 == 0);
				endcase
			end
			rsp_stall <= stall_next;
		end
	end

	initial begin : watchdog
		int idle;
		idle = 0;
		while (idle < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				idle = 0;
			else
				idle++;
		end
		$display("FAILED: results differ");
		$finish;
	end
endmodule

FILE: sim.f
+incdir+design
design/cenum_pkg.sv
design/cenum_ctrl.sv
design/cenum_dp.sv
design/combination_enumerator_core.sv
design/combination_enumerator_core_chk.sv
verif/combination_enumerator_core_test.sv
